@@ hdl/scds_pkg.sv @@
// types, character codes and segment lookup for the serial command display store
package scds_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  reply_code;
    logic [63:0] stored_digits;
    logic [7:0]  digit_select;
    logic [7:0]  segment_pattern;
  } result_t;

  localparam logic       MODE_BYTE    = 1'b0;
  localparam logic       MODE_TICK    = 1'b1;
  localparam logic       KIND_REPLY   = 1'b0;
  localparam logic       KIND_DISPLAY = 1'b1;
  localparam logic [1:0] REPLY_ACK    = 2'd0;
  localparam logic [1:0] REPLY_FAIL   = 2'd1;
  localparam logic [1:0] REPLY_DATA   = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_N       = 8'h4E;
  localparam logic [7:0] BLANK_MARK = 8'h45;
  localparam logic [7:0] SEG_OFF    = 8'hFF;

  function automatic logic [7:0] seg_of(input logic [7:0] ch);
    logic [7:0] seg;
    unique case (ch)
      8'h30:   seg = 8'hC0;
      8'h31:   seg = 8'hF9;
      8'h32:   seg = 8'hA4;
      8'h33:   seg = 8'hB0;
      8'h34:   seg = 8'h99;
      8'h35:   seg = 8'h92;
      8'h36:   seg = 8'h82;
      8'h37:   seg = 8'hF8;
      8'h38:   seg = 8'h80;
      8'h39:   seg = 8'h90;
      default: seg = SEG_OFF;
    endcase
    return seg;
  endfunction

endpackage

@@ hdl/scds_core.sv @@
// line buffer, command decode, digit store and display scan
module scds_core #(
  parameter int LINE_DEPTH  = 16,
  parameter int DIGIT_COUNT = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  scds_pkg::item_t  item,
  output logic             push,
  output scds_pkg::result_t push_data
);

  localparam int IDX_W = $clog2(LINE_DEPTH + 1);
  localparam int AD_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int KEEP  = DIGIT_COUNT + 1;

  logic [IDX_W-1:0] line_index;
  logic [IDX_W-1:0] line_index_next;
  logic [IDX_W-1:0] idx_w;
  logic [7:0]       line_buf [KEEP];
  logic [7:0]       digit_store [DIGIT_COUNT];
  logic [7:0]       digit_store_next [DIGIT_COUNT];
  logic [AD_W-1:0]  active_digit;
  logic [AD_W-1:0]  active_digit_next;
  logic             load_go;

  always_comb begin
    idx_w = (line_index >= IDX_W'(LINE_DEPTH)) ? '0 : line_index;
    line_index_next   = line_index;
    active_digit_next = active_digit;
    digit_store_next  = digit_store;
    push      = 1'b0;
    push_data = '0;
    load_go   = 1'b1;
    if (accept) begin
      if (item.mode == scds_pkg::MODE_TICK) begin
        active_digit_next = (active_digit == AD_W'(DIGIT_COUNT - 1)) ? '0
                          : active_digit + AD_W'(1);
        push = 1'b1;
        push_data.result_kind     = scds_pkg::KIND_DISPLAY;
        push_data.digit_select    = ~(8'(1) << active_digit_next);
        push_data.segment_pattern = scds_pkg::seg_of(digit_store[active_digit_next]);
      end else if (item.rx_byte != scds_pkg::CH_NEWLINE) begin
        line_index_next = idx_w + IDX_W'(1);
      end else begin
        line_index_next = '0;
        push = 1'b1;
        push_data.result_kind = scds_pkg::KIND_REPLY;
        push_data.reply_code  = scds_pkg::REPLY_FAIL;
        if (idx_w != '0) begin
          priority if (line_buf[0] == scds_pkg::CH_A) begin
            push_data.reply_code = scds_pkg::REPLY_ACK;
          end else if (line_buf[0] == scds_pkg::CH_C) begin
            push_data.reply_code = scds_pkg::REPLY_ACK;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
              digit_store_next[i] = scds_pkg::BLANK_MARK;
            end
          end else if (line_buf[0] == scds_pkg::CH_D) begin
            push_data.reply_code = scds_pkg::REPLY_DATA;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
              push_data.stored_digits[8*i +: 8] = digit_store[i];
            end
          end else if (line_buf[0] == scds_pkg::CH_N) begin
            push = 1'b0;
            push_data = '0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
              load_go = load_go && (IDX_W'(i + 1) < idx_w)
                        && (line_buf[i+1] != scds_pkg::CH_RETURN);
              digit_store_next[i] = load_go ? line_buf[i+1] : scds_pkg::BLANK_MARK;
            end
          end else begin
            push_data.reply_code = scds_pkg::REPLY_FAIL;
          end
        end
      end
    end
  end

  // only the head of the line is ever read back
  always_ff @(posedge clk) begin
    for (int k = 0; k < KEEP; k++) begin
      if (accept && item.mode == scds_pkg::MODE_BYTE && idx_w == IDX_W'(k)) begin
        line_buf[k] <= item.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_index   <= '0;
      active_digit <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_store[i] <= scds_pkg::BLANK_MARK;
      end
    end else begin
      line_index   <= line_index_next;
      active_digit <= active_digit_next;
      digit_store  <= digit_store_next;
    end
  end

endmodule

@@ hdl/scds_out_buf.sv @@
// two-entry result buffer with skid stage
module scds_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  scds_pkg::result_t push_data,
  output logic              full,
  output logic              result_valid,
  input  logic              result_stall,
  output scds_pkg::result_t result
);

  logic              main_valid;
  logic              skid_valid;
  scds_pkg::result_t main_data;
  scds_pkg::result_t skid_data;
  logic              pop;

  assign pop          = main_valid && !result_stall;
  assign full         = skid_valid;
  assign result_valid = main_valid;
  assign result       = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds a beat while main is empty");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("beat pushed into a full buffer");
`endif

endmodule

@@ hdl/serial_command_display_store_unit.sv @@
// top level of the serial command display store
//
//   channel  | direction | handshake                  | payload
//   item     | in        | item_valid / item_stall     | scds_pkg::item_t
//   result   | out       | result_valid / result_stall | scds_pkg::result_t
//
// one item per cycle unless stalled; its result, if any, is registered in u_out_buf
// all state updates in the cycle of acceptance, set by the decode logic in scds_core
// rst clears line position, scan digit and the store (to the blank marker)
// a stalled result is held while one more beat fills the skid stage
// item_stall rises only while both result entries are occupied
module serial_command_display_store_unit #(
  parameter int LINE_DEPTH  = 16,
  parameter int DIGIT_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  scds_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output scds_pkg::result_t result
);

  logic              accept;
  logic              push;
  logic              full;
  scds_pkg::result_t push_data;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  scds_core #(
    .LINE_DEPTH  (LINE_DEPTH),
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .push      (push),
    .push_data (push_data)
  );

  scds_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_display_one_digit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == scds_pkg::KIND_DISPLAY
      |-> $countones(~result.digit_select) == 1 && result.reply_code == scds_pkg::REPLY_ACK)
    else $error("display beat without a single selected digit");
  a_reply_no_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == scds_pkg::KIND_REPLY
      |-> result.digit_select == 8'h00 && result.segment_pattern == 8'h00)
    else $error("reply beat carries display drive");
  a_data_only_for_read: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.reply_code != scds_pkg::REPLY_DATA |-> result.stored_digits == '0)
    else $error("stored digits attached to a non-read beat");
`endif

endmodule

@@ bench/scds_checker.sv @@
// checker for the serial command display store: predicts and compares result beats
`timescale 1ns / 1ps
module scds_checker #(
  parameter int LINE_DEPTH  = 16,
  parameter int DIGIT_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  scds_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  scds_pkg::result_t result,
  output int                fail_count,
  output int                pending,
  output int                reply_count,
  output int                update_count
);

  // active-low patterns, digit 0 in the low byte
  localparam logic [79:0] DIGIT_SEGS = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                        8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

  logic [7:0]        line_buf [LINE_DEPTH];
  logic [7:0]        store [DIGIT_COUNT];
  int unsigned       line_pos;
  int unsigned       scan_digit;
  int                errs;
  int                replies;
  int                updates;
  scds_pkg::result_t awaited_results [$];

  function automatic bit step_store(input scds_pkg::item_t it, output scds_pkg::result_t r);
    int unsigned len;
    int unsigned n;
    int          i;
    logic [7:0]  entry;
    r = '0;
    if (it.mode == scds_pkg::MODE_TICK) begin
      scan_digit = (scan_digit + 1 >= DIGIT_COUNT) ? 0 : scan_digit + 1;
      entry = store[scan_digit];
      r.result_kind = scds_pkg::KIND_DISPLAY;
      r.digit_select = ~(8'd1 << scan_digit);
      r.segment_pattern = scds_pkg::SEG_OFF;
      if (entry >= "0" && entry <= "9") begin
        r.segment_pattern = DIGIT_SEGS[8 * (entry - "0") +: 8];
      end
      return 1'b1;
    end
    if (line_pos >= LINE_DEPTH) line_pos = 0;
    line_buf[line_pos] = it.rx_byte;
    if (it.rx_byte != scds_pkg::CH_NEWLINE) begin
      line_pos++;
      return 1'b0;
    end
    len = line_pos;
    line_pos = 0;
    r.result_kind = scds_pkg::KIND_REPLY;
    r.reply_code = scds_pkg::REPLY_FAIL;
    if (len == 0) return 1'b1;
    case (line_buf[0])
      scds_pkg::CH_A: begin
        r.reply_code = scds_pkg::REPLY_ACK;
      end
      scds_pkg::CH_C: begin
        for (i = 0; i < DIGIT_COUNT; i++) store[i] = scds_pkg::BLANK_MARK;
        r.reply_code = scds_pkg::REPLY_ACK;
      end
      scds_pkg::CH_D: begin
        r.reply_code = scds_pkg::REPLY_DATA;
        for (i = 0; i < DIGIT_COUNT && i < 8; i++) begin
          r.stored_digits[8 * i +: 8] = store[i];
        end
      end
      scds_pkg::CH_N: begin
        n = 0;
        while (n < DIGIT_COUNT && n + 1 < len && line_buf[n + 1] != scds_pkg::CH_RETURN) begin
          store[n] = line_buf[n + 1];
          n++;
        end
        for (i = n; i < DIGIT_COUNT; i++) store[i] = scds_pkg::BLANK_MARK;
        return 1'b0;
      end
      default: begin
      end
    endcase
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  initial begin
    errs = 0;
    replies = 0;
    updates = 0;
  end

  always @(posedge clk) begin : watch
    int                i;
    scds_pkg::result_t want;
    if (rst) begin
      awaited_results.delete();
      line_pos = 0;
      scan_digit = 0;
      for (i = 0; i < DIGIT_COUNT; i++) store[i] = scds_pkg::BLANK_MARK;
    end else begin
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          errs++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", want.result_kind, result.result_kind);
          check_field("reply_code", want.reply_code, result.reply_code);
          check_field("stored_digits", want.stored_digits, result.stored_digits);
          check_field("digit_select", want.digit_select, result.digit_select);
          check_field("segment_pattern", want.segment_pattern, result.segment_pattern);
          if (want.result_kind == scds_pkg::KIND_REPLY) replies++;
          else updates++;
        end
      end
      if (item_valid && !item_stall) begin
        if (step_store(item, want)) awaited_results.push_back(want);
      end
    end
    pending <= awaited_results.size();
    fail_count <= errs;
    reply_count <= replies;
    update_count <= updates;
  end

endmodule

@@ bench/serial_command_display_store_unit_tb.sv @@
// testbench top for the serial command display store: reset, directed and random stimulus, verdict
`timescale 1ns / 1ps
module serial_command_display_store_unit_tb;

  localparam int RUN_LIMIT   = 200000;
  localparam int PHASE_ITEMS = 375;
  localparam int LINE_WRAP   = 16;

  logic              clk;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  scds_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  scds_pkg::result_t result;

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int fail_count;
  int pending;
  int reply_count;
  int update_count;

  serial_command_display_store_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  scds_checker #(.LINE_DEPTH(16), .DIGIT_COUNT(8)) u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .reply_count  (reply_count),
    .update_count (update_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input logic m, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= scds_pkg::item_t'({m, b});
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_line(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_item(scds_pkg::MODE_BYTE, s[k]);
    send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_NEWLINE);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == scds_pkg::CH_NEWLINE);
    return b;
  endfunction

  task automatic send_command();
    int pick;
    int sel;
    int k;
    int count;
    pick = $urandom_range(99);
    if (pick < 20) begin
      send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_A);
    end else if (pick < 32) begin
      send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_C);
    end else if (pick < 52) begin
      send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_D);
    end else if (pick < 85) begin
      send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_N);
      count = $urandom_range(10);
      for (k = 0; k < count; k++) begin
        sel = $urandom_range(9);
        if (sel < 7) send_item(scds_pkg::MODE_BYTE, "0" + 8'($urandom_range(9)));
        else if (sel == 7) send_item(scds_pkg::MODE_BYTE, scds_pkg::BLANK_MARK);
        else send_item(scds_pkg::MODE_BYTE, text_byte());
      end
      if ($urandom_range(2) == 0) send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_RETURN);
    end else if (pick < 95) begin
      send_item(scds_pkg::MODE_BYTE, text_byte());
    end
    // trailing text, left off empty lines
    if (pick < 95 && $urandom_range(3) == 0) begin
      count = $urandom_range(1, 3);
      for (k = 0; k < count; k++) send_item(scds_pkg::MODE_BYTE, text_byte());
    end
    send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_NEWLINE);
  endtask

  task automatic random_burst();
    int pick;
    int count;
    pick = $urandom_range(99);
    if (pick < 35) begin
      repeat ($urandom_range(1, 10)) send_item(scds_pkg::MODE_TICK, 8'($urandom));
    end else if (pick < 85) begin
      send_command();
    end else if (pick < 93) begin
      // long text before the command; the buffer restarts just before it only for a multiple of LINE_WRAP
      count = ($urandom_range(1) == 0) ? LINE_WRAP : $urandom_range(14, 40);
      repeat (count) send_item(scds_pkg::MODE_BYTE, text_byte());
      send_command();
    end else begin
      repeat ($urandom_range(1, 6)) send_item(1'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int target;
    idle_pct = idle;
    stall_pct = stall;
    target = items_sent + count;
    while (items_sent < target) random_burst();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(scds_pkg::MODE_TICK, 8'hFF);
    send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_NEWLINE);
    send_line("A");
    send_line("Z");
    send_line("D");
    send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_N);
    send_item(scds_pkg::MODE_BYTE, "0");
    send_item(scds_pkg::MODE_BYTE, "9");
    send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_RETURN);
    send_item(scds_pkg::MODE_BYTE, "7");
    send_item(scds_pkg::MODE_BYTE, scds_pkg::CH_NEWLINE);
    send_line("D");
    repeat (8) send_item(scds_pkg::MODE_TICK, 8'h00);
    send_line("C");

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(81, 0, PHASE_ITEMS);
    run_phase(0, 81, PHASE_ITEMS);
    run_phase(26, 26, PHASE_ITEMS);

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d items sent: A/C/D/N commands, bad and empty lines, buffer wrap and ticks",
             items_sent);
    $display("%0d replies and %0d display updates checked across four idle/stall phases",
             reply_count, update_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ serial_command_display_store_unit.f @@
hdl/scds_pkg.sv
hdl/scds_core.sv
hdl/scds_out_buf.sv
hdl/serial_command_display_store_unit.sv
bench/scds_checker.sv
bench/serial_command_display_store_unit_tb.sv
